[rtl/assert_macros.svh]
// Assertion macros for the RTL files; the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Plain invariant checked on every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

[rtl/sgas_pkg.sv]
// Package of the segregation grid agent step block: types, codes, defaults.
package sgas_pkg;

    localparam int ROWS_DEFAULT       = 256;
    localparam int COLS_DEFAULT       = 256;
    localparam int MAX_RADIUS_DEFAULT = 7;

    localparam int CFG_DW = 56;
    localparam int CFG_IW = 2;

    localparam logic [CFG_IW-1:0] CFG_RADIUS     = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_UNIFORM    = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_TOL_SHARED = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_TOL_COLOUR = 2'd3;

    localparam logic [2:0]  RADIUS_RESET     = 3'd2;
    localparam logic        UNIFORM_RESET    = 1'b1;
    localparam logic [7:0]  TOL_SHARED_RESET = 8'd7;
    localparam logic [55:0] TOL_COLOUR_RESET = 56'h07070707070707;

    localparam logic [1:0] STATUS_STAY   = 2'd0;
    localparam logic [1:0] STATUS_MOVED  = 2'd1;
    localparam logic [1:0] STATUS_NOFREE = 2'd2;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_VISIT = 1'b1;

    typedef struct packed {
        logic        func;
        logic [7:0]  row;
        logic [7:0]  col;
        logic [2:0]  colour;
        logic [31:0] random_value;
    } t_in_word;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] dest_row;
        logic [7:0] dest_col;
        logic [7:0] foreign_count;
    } t_out_word;

endpackage

[rtl/sgas_ram.sv]
// Generic single-port RAM with registered read data.
module sgas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

[rtl/segregation_grid_agent_step.sv]
// Top level: toroidal segregation grid with free list, one agent step per word.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+----------------------
//  input    | in        | i_in_valid / o_in_ready    | i_in_word  (t_in_word)
//  output   | out       | o_out_valid / i_out_ready  | o_out_word (t_out_word)
//  config   | in        | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// After reset the grid memory is cleared one cell a cycle, all ROWS*COLS cells
// (65536 by default), with the input not ready; config writes are taken.
// A load reduces the coordinates, writes the cell and, for colour 0, adds it to the free list.
// A visit scans the (2r+1)^2 window through the one grid port; a move adds
// the bit-serial modulo and the swap.
// One word is in work at a time; a finished result waits in the output
// register while the next word is accepted.
module segregation_grid_agent_step #(
    parameter int ROWS       = sgas_pkg::ROWS_DEFAULT,
    parameter int COLS       = sgas_pkg::COLS_DEFAULT,
    parameter int MAX_RADIUS = sgas_pkg::MAX_RADIUS_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  sgas_pkg::t_in_word          i_in_word,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output sgas_pkg::t_out_word         o_out_word,
    input  logic                        i_cfg_we,
    input  logic [sgas_pkg::CFG_IW-1:0] i_cfg_idx,
    input  logic [sgas_pkg::CFG_DW-1:0] i_cfg_data
);
`include "assert_macros.svh"

    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + 1);
    localparam int RW    = $clog2(ROWS);
    localparam int CLW   = $clog2(COLS);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_REDUCE = 4'd2;
    localparam logic [3:0] ST_LOAD   = 4'd3;
    localparam logic [3:0] ST_OWN_RD = 4'd4;
    localparam logic [3:0] ST_OWN    = 4'd5;
    localparam logic [3:0] ST_SCAN   = 4'd6;
    localparam logic [3:0] ST_DRAIN  = 4'd7;
    localparam logic [3:0] ST_DECIDE = 4'd8;
    localparam logic [3:0] ST_DIV    = 4'd9;
    localparam logic [3:0] ST_FL_RD  = 4'd10;
    localparam logic [3:0] ST_FL_CAP = 4'd11;
    localparam logic [3:0] ST_K_CAP  = 4'd12;
    localparam logic [3:0] ST_WR_K   = 4'd13;
    localparam logic [3:0] ST_WR_H   = 4'd14;
    localparam logic [3:0] ST_DONE   = 4'd15;

    // Configuration registers.
    logic [2:0]  r_radius;
    logic        r_uniform;
    logic [7:0]  r_tol_shared;
    logic [55:0] r_tol_colour;

    // Control state.
    logic [3:0]    r_state;
    logic [AW-1:0] r_clr;
    logic [CW-1:0] r_free_cnt;
    logic          r_out_valid;
    sgas_pkg::t_out_word r_out;

    // Word under work.
    logic        r_func;
    logic [7:0]  r_row, r_col;
    logic [2:0]  r_colour;
    logic [31:0] r_rnd;
    logic [2:0]  r_own;
    logic [RW-1:0]  r_rr;
    logic [CLW-1:0] r_cc, r_c0;
    logic [3:0]  r_i, r_j;
    logic        r_pend;
    logic [7:0]  r_fc;
    logic [4:0]  r_bit;
    logic [CW-1:0] r_rem;
    logic [7:0]  r_krow, r_kcol;
    logic [2:0]  r_t;
    logic [1:0]  r_status;
    logic [7:0]  r_drow, r_dcol;

    // Memory ports.
    logic          grid_we;
    logic [AW-1:0] grid_addr;
    logic [2:0]    grid_wdata, grid_rdata;
    logic          fl_we;
    logic [AW-1:0] fl_addr;
    logic [15:0]   fl_wdata, fl_rdata;

    sgas_ram #(.WIDTH(3), .DEPTH(CELLS)) u_grid (
        .i_clk   (i_clk),
        .i_we    (grid_we),
        .i_addr  (grid_addr),
        .i_wdata (grid_wdata),
        .o_rdata (grid_rdata)
    );

    sgas_ram #(.WIDTH(16), .DEPTH(CELLS)) u_free (
        .i_clk   (i_clk),
        .i_we    (fl_we),
        .i_addr  (fl_addr),
        .i_wdata (fl_wdata),
        .o_rdata (fl_rdata)
    );

    // Cell address from row and column: one small constant multiply.
    function automatic logic [AW-1:0] cell_addr(input logic [7:0] row, input logic [7:0] col);
        logic [AW+8:0] a;
        a = {{(AW+1){1'b0}}, row} * (AW+9)'(COLS) + {{(AW+1){1'b0}}, col};
        return a[AW-1:0];
    endfunction

    // Derived values.
    logic [2:0]    rad;
    logic [3:0]    span_m1;
    logic [9:0]    r_start_raw, c_start_raw;
    logic [RW-1:0] r_start;
    logic [CLW-1:0] c_start;
    logic [AW-1:0] here_addr, win_addr, k_addr;
    logic          hit;
    logic [7:0]    fc_next;
    logic [7:0]    tol;
    logic [CW:0]   rem_sh;
    logic [CW:0]   rem_sub;
    logic          row_big, col_big;

    always_comb begin
        rad = (r_radius > 3'(MAX_RADIUS)) ? 3'(MAX_RADIUS) : r_radius;
        span_m1 = {rad, 1'b0};
        // Window origin, wrapped once toward the far edge.
        r_start_raw = {2'b0, r_row} + 10'(ROWS) - {7'b0, rad};
        c_start_raw = {2'b0, r_col} + 10'(COLS) - {7'b0, rad};
        if (r_start_raw >= 10'(ROWS)) begin
            r_start_raw = r_start_raw - 10'(ROWS);
        end
        if (c_start_raw >= 10'(COLS)) begin
            c_start_raw = c_start_raw - 10'(COLS);
        end
        r_start = r_start_raw[RW-1:0];
        c_start = c_start_raw[CLW-1:0];
        here_addr = cell_addr(r_row, r_col);
        win_addr  = cell_addr(8'(r_rr), 8'(r_cc));
        k_addr    = cell_addr(r_krow, r_kcol);
        hit = r_pend && (grid_rdata != 3'd0) && (grid_rdata != r_own);
        fc_next = r_fc + {7'b0, hit};
        case (r_own)
            3'd1:    tol = r_tol_colour[7:0];
            3'd2:    tol = r_tol_colour[15:8];
            3'd3:    tol = r_tol_colour[23:16];
            3'd4:    tol = r_tol_colour[31:24];
            3'd5:    tol = r_tol_colour[39:32];
            3'd6:    tol = r_tol_colour[47:40];
            3'd7:    tol = r_tol_colour[55:48];
            default: tol = 8'd0;
        endcase
        if (r_uniform) begin
            tol = r_tol_shared;
        end
        // One restoring step of random_value mod free count.
        rem_sh  = {r_rem, r_rnd[r_bit]};
        rem_sub = rem_sh - {1'b0, r_free_cnt};
        row_big = {1'b0, r_row} >= 9'(ROWS);
        col_big = {1'b0, r_col} >= 9'(COLS);
    end

    // Memory port steering.
    always_comb begin
        grid_we    = 1'b0;
        grid_addr  = here_addr;
        grid_wdata = r_colour;
        fl_we      = 1'b0;
        fl_addr    = r_rem[AW-1:0];
        fl_wdata   = {r_row, r_col};
        case (r_state)
            ST_CLEAR: begin
                grid_we    = 1'b1;
                grid_addr  = r_clr;
                grid_wdata = 3'd0;
            end
            ST_LOAD: begin
                grid_we = 1'b1;
                fl_addr = r_free_cnt[AW-1:0];
                fl_we   = (r_colour == 3'd0) && (r_free_cnt < CW'(CELLS));
            end
            ST_SCAN: grid_addr = win_addr;
            ST_FL_CAP: grid_addr = cell_addr(fl_rdata[15:8], fl_rdata[7:0]);
            ST_WR_K: begin
                grid_we    = 1'b1;
                grid_addr  = k_addr;
                grid_wdata = r_own;
            end
            ST_WR_H: begin
                grid_we    = 1'b1;
                grid_wdata = r_t;
                fl_we      = 1'b1;
            end
            default: ;
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius     <= sgas_pkg::RADIUS_RESET;
            r_uniform    <= sgas_pkg::UNIFORM_RESET;
            r_tol_shared <= sgas_pkg::TOL_SHARED_RESET;
            r_tol_colour <= sgas_pkg::TOL_COLOUR_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sgas_pkg::CFG_RADIUS:     r_radius     <= i_cfg_data[2:0];
                sgas_pkg::CFG_UNIFORM:    r_uniform    <= i_cfg_data[0];
                sgas_pkg::CFG_TOL_SHARED: r_tol_shared <= i_cfg_data[7:0];
                sgas_pkg::CFG_TOL_COLOUR: r_tol_colour <= i_cfg_data[55:0];
                default: ;
            endcase
        end
    end

    // Control: sequencer, free count, output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_free_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Raise valid on a finished word, drop it once the word is taken.
            if (r_state == ST_DONE && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(CELLS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_REDUCE;
                    end
                end
                ST_REDUCE: begin
                    if (!row_big && !col_big) begin
                        r_state <= (r_func == sgas_pkg::FUNC_LOAD) ? ST_LOAD : ST_OWN_RD;
                    end
                end
                ST_LOAD: begin
                    if (fl_we) begin
                        r_free_cnt <= r_free_cnt + CW'(1);
                    end
                    r_state <= ST_DONE;
                end
                ST_OWN_RD: r_state <= ST_OWN;
                ST_OWN: r_state <= (grid_rdata == 3'd0) ? ST_DONE : ST_SCAN;
                ST_SCAN: begin
                    if (r_j == span_m1 && r_i == span_m1) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: r_state <= ST_DECIDE;
                ST_DECIDE: begin
                    if (r_fc >= tol && r_free_cnt != '0) begin
                        r_state <= ST_DIV;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DIV: begin
                    if (r_bit == 5'd0) begin
                        r_state <= ST_FL_RD;
                    end
                end
                ST_FL_RD:  r_state <= ST_FL_CAP;
                ST_FL_CAP: r_state <= ST_K_CAP;
                ST_K_CAP:  r_state <= ST_WR_K;
                ST_WR_K:   r_state <= ST_WR_H;
                ST_WR_H:   r_state <= ST_DONE;
                ST_DONE: begin
                    // Hold the result until the output register frees up.
                    if (!r_out_valid || i_out_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_func   <= i_in_word.func;
                r_row    <= i_in_word.row;
                r_col    <= i_in_word.col;
                r_colour <= i_in_word.colour;
                r_rnd    <= i_in_word.random_value;
            end
            ST_REDUCE: begin
                // Reduce coordinates one subtraction a cycle.
                if (row_big) begin
                    r_row <= 8'({1'b0, r_row} - 9'(ROWS));
                end
                if (col_big) begin
                    r_col <= 8'({1'b0, r_col} - 9'(COLS));
                end
                r_status <= sgas_pkg::STATUS_STAY;
                r_fc     <= 8'd0;
            end
            ST_LOAD: begin
                r_drow <= r_row;
                r_dcol <= r_col;
            end
            ST_OWN: begin
                r_own  <= grid_rdata;
                r_drow <= r_row;
                r_dcol <= r_col;
                r_rr   <= r_start;
                r_cc   <= c_start;
                r_c0   <= c_start;
                r_i    <= 4'd0;
                r_j    <= 4'd0;
                r_pend <= 1'b0;
            end
            ST_SCAN: begin
                // Issue one window read a cycle, count the one before.
                r_fc   <= fc_next;
                r_pend <= 1'b1;
                if (r_j == span_m1) begin
                    r_j  <= 4'd0;
                    r_cc <= r_c0;
                    r_i  <= r_i + 4'd1;
                    r_rr <= (r_rr == RW'(ROWS - 1)) ? '0 : r_rr + RW'(1);
                end else begin
                    r_j  <= r_j + 4'd1;
                    r_cc <= (r_cc == CLW'(COLS - 1)) ? '0 : r_cc + CLW'(1);
                end
            end
            ST_DRAIN: r_fc <= fc_next;
            ST_DECIDE: begin
                if (r_fc >= tol && r_free_cnt == '0) begin
                    r_status <= sgas_pkg::STATUS_NOFREE;
                end
                r_rem <= '0;
                r_bit <= 5'd31;
            end
            ST_DIV: begin
                r_rem <= rem_sub[CW] ? rem_sh[CW-1:0] : rem_sub[CW-1:0];
                r_bit <= r_bit - 5'd1;
            end
            ST_FL_CAP: begin
                r_krow <= fl_rdata[15:8];
                r_kcol <= fl_rdata[7:0];
            end
            ST_K_CAP: r_t <= grid_rdata;
            ST_WR_H: begin
                r_status <= sgas_pkg::STATUS_MOVED;
                r_drow   <= r_krow;
                r_dcol   <= r_kcol;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    r_out.status        <= r_status;
                    r_out.dest_row      <= r_drow;
                    r_out.dest_col      <= r_dcol;
                    r_out.foreign_count <= r_fc;
                end
            end
            default: ;
        endcase
    end

    `ASSERT_ALWAYS(a_free_cnt_bound, i_clk, i_rst_n, r_free_cnt <= CW'(CELLS), "free count past grid size")
    `ASSERT_CLK(a_accept_to_reduce, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> (r_state == ST_REDUCE), "accepted word not taken into work")
    `ASSERT_CLK(a_move_needs_free, i_clk, i_rst_n, (r_state == ST_DIV) |-> (r_free_cnt != '0), "modulo by empty free list")

endmodule

[dv/tb.sv]
// Testbench for the segregation grid agent step block: directed table, random phases.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_CELLS = 65536;
    localparam int PHASES     = 10;
    localparam int PHASE_LEN  = 113;

    // One directed row: the word to send and, where it is obvious, the result.
    typedef struct {
        sgas_pkg::t_in_word  w;
        bit                  typed;
        sgas_pkg::t_out_word res;
    } t_table_row;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    sgas_pkg::t_in_word            i_in_word;
    logic                          o_out_valid;
    logic                          i_out_ready;
    sgas_pkg::t_out_word           o_out_word;
    logic                          i_cfg_we;
    logic [sgas_pkg::CFG_IW-1:0]   i_cfg_idx;
    logic [sgas_pkg::CFG_DW-1:0]   i_cfg_data;

    // Mirror of the block: grid colours, free cell list, registers.
    logic [2:0]  grid_colour [GRID_CELLS];
    logic [15:0] free_cells  [GRID_CELLS];
    logic [16:0] free_total;
    logic [2:0]  win_radius;
    logic        shared_tol_on;
    logic [7:0]  tol_all;
    logic [55:0] tol_per_colour;

    sgas_pkg::t_out_word pending_results[$];
    t_table_row  steps[$];
    int          n_errors;
    int          n_words;
    int          n_moves;
    int          n_nofree;
    int          n_cfg;
    bit          no_idle;
    int          ready_hold;

    segregation_grid_agent_step dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Count foreign agents in the wrapped square window around (r0, c0).
    function automatic int count_foreign(logic [7:0] r0, logic [7:0] c0, logic [2:0] own);
        int          rad;
        int          cnt;
        logic [7:0]  rr;
        logic [7:0]  cc;
        logic [2:0]  v;
        rad = win_radius;
        cnt = 0;
        for (int i = -rad; i <= rad; i++) begin
            for (int j = -rad; j <= rad; j++) begin
                rr = r0 + i[7:0];
                cc = c0 + j[7:0];
                v  = grid_colour[{rr, cc}];
                if (v != 3'd0 && v != own) begin
                    cnt++;
                end
            end
        end
        return cnt;
    endfunction

    // Apply one word to the mirror and return the result it must produce.
    function automatic sgas_pkg::t_out_word agent_step(sgas_pkg::t_in_word w);
        sgas_pkg::t_out_word res;
        logic [15:0] here;
        logic [15:0] dest;
        logic [2:0]  own;
        logic [2:0]  swap;
        logic [7:0]  tol;
        logic [31:0] slot;
        int          fc;
        here = {w.row, w.col};
        res.status = sgas_pkg::STATUS_STAY;
        res.dest_row = w.row;
        res.dest_col = w.col;
        res.foreign_count = 8'd0;
        if (w.func == sgas_pkg::FUNC_LOAD) begin
            grid_colour[here] = w.colour;
            if (w.colour == 3'd0 && free_total < GRID_CELLS) begin
                free_cells[free_total] = here;
                free_total++;
            end
        end else begin
            own = grid_colour[here];
            if (own != 3'd0) begin
                fc = count_foreign(w.row, w.col, own);
                res.foreign_count = fc[7:0];
                tol = shared_tol_on ? tol_all : tol_per_colour[8*(own-1) +: 8];
                if (fc >= tol) begin
                    if (free_total == 0) begin
                        res.status = sgas_pkg::STATUS_NOFREE;
                    end else begin
                        slot = w.random_value % {15'd0, free_total};
                        dest = free_cells[slot];
                        swap = grid_colour[dest];
                        grid_colour[dest] = own;
                        grid_colour[here] = swap;
                        free_cells[slot] = here;
                        res.status = sgas_pkg::STATUS_MOVED;
                        res.dest_row = dest[15:8];
                        res.dest_col = dest[7:0];
                    end
                end
            end
        end
        return res;
    endfunction

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
            n_errors++;
        end
    endtask

    // Take results with random back-pressure; compare each with the oldest pending one.
    always @(posedge i_clk) begin
        sgas_pkg::t_out_word exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing pending, got %p", $time, o_out_word);
                n_errors++;
            end else begin
                exp_res = pending_results.pop_front();
                check_field("status", exp_res.status, o_out_word.status);
                check_field("dest_row", exp_res.dest_row, o_out_word.dest_row);
                check_field("dest_col", exp_res.dest_col, o_out_word.dest_col);
                check_field("foreign_count", exp_res.foreign_count, o_out_word.foreign_count);
            end
        end
        // Hold ready low for a random stretch, mostly short, now and then long.
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            i_out_ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 99) < 30) begin
            ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Present one word, hold it until taken, then log what it should produce.
    task automatic send_word(sgas_pkg::t_in_word w, bit typed, sgas_pkg::t_out_word typed_res);
        sgas_pkg::t_out_word res;
        int        gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        res = agent_step(w);
        if (res.status == sgas_pkg::STATUS_MOVED) n_moves++;
        if (res.status == sgas_pkg::STATUS_NOFREE) n_nofree++;
        pending_results.insert(pending_results.size(), typed ? typed_res : res);
        n_words++;
    endtask

    // Drop valid and drain: every pending result in, then a margin for the block to settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [sgas_pkg::CFG_IW-1:0] idx,
                             logic [sgas_pkg::CFG_DW-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            sgas_pkg::CFG_RADIUS:     win_radius     = data[2:0];
            sgas_pkg::CFG_UNIFORM:    shared_tol_on  = data[0];
            sgas_pkg::CFG_TOL_SHARED: tol_all        = data[7:0];
            sgas_pkg::CFG_TOL_COLOUR: tol_per_colour = data[55:0];
            default: ;
        endcase
        n_cfg++;
    endtask

    task automatic add_row(logic func, logic [7:0] r, logic [7:0] c, logic [2:0] colour,
                           logic [31:0] rnd, bit typed, logic [1:0] st, logic [7:0] fc);
        t_table_row row;
        row.w = '{func: func, row: r, col: c, colour: colour, random_value: rnd};
        row.typed = typed;
        row.res = '{status: st, dest_row: r, dest_col: c, foreign_count: fc};
        steps.insert(steps.size(), row);
    endtask

    initial begin
        sgas_pkg::t_in_word w;
        logic [7:0]  base_r;
        logic [7:0]  base_c;
        logic [55:0] tol_word;
        logic [2:0]  rad;
        int          pick;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        ready_hold  = 0;
        no_idle     = 1'b0;
        n_errors = 0; n_words = 0; n_moves = 0; n_nofree = 0; n_cfg = 0;
        foreach (grid_colour[k]) grid_colour[k] = 3'd0;
        foreach (free_cells[k]) free_cells[k] = 16'd0;
        free_total     = '0;
        win_radius     = sgas_pkg::RADIUS_RESET;
        shared_tol_on  = sgas_pkg::UNIFORM_RESET;
        tol_all        = sgas_pkg::TOL_SHARED_RESET;
        tol_per_colour = sgas_pkg::TOL_COLOUR_RESET;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table, reset registers (radius 2, shared tolerance 7).
        add_row(sgas_pkg::FUNC_LOAD,  8'd0,   8'd0,   3'd1, 32'd0, 1,
                sgas_pkg::STATUS_STAY, 8'd0);
        add_row(sgas_pkg::FUNC_VISIT, 8'd0,   8'd0,   3'd0, 32'd0, 1,
                sgas_pkg::STATUS_STAY, 8'd0);
        // Surround the agent with another colour across the wrapped corner.
        add_row(sgas_pkg::FUNC_LOAD,  8'd255, 8'd255, 3'd2, 32'd0, 1,
                sgas_pkg::STATUS_STAY, 8'd0);
        add_row(sgas_pkg::FUNC_LOAD,  8'd255, 8'd0,   3'd2, 32'd0, 1,
                sgas_pkg::STATUS_STAY, 8'd0);
        add_row(sgas_pkg::FUNC_LOAD,  8'd255, 8'd1,   3'd2, 32'd0, 1,
                sgas_pkg::STATUS_STAY, 8'd0);
        add_row(sgas_pkg::FUNC_LOAD,  8'd0,   8'd255, 3'd2, 32'd0, 1,
                sgas_pkg::STATUS_STAY, 8'd0);
        add_row(sgas_pkg::FUNC_LOAD,  8'd0,   8'd1,   3'd2, 32'd0, 1,
                sgas_pkg::STATUS_STAY, 8'd0);
        add_row(sgas_pkg::FUNC_LOAD,  8'd1,   8'd255, 3'd2, 32'd0, 1,
                sgas_pkg::STATUS_STAY, 8'd0);
        add_row(sgas_pkg::FUNC_LOAD,  8'd1,   8'd0,   3'd2, 32'd0, 1,
                sgas_pkg::STATUS_STAY, 8'd0);
        add_row(sgas_pkg::FUNC_LOAD,  8'd1,   8'd1,   3'd2, 32'd0, 1,
                sgas_pkg::STATUS_STAY, 8'd0);
        // Unhappy with an empty free list: stay and flag.
        add_row(sgas_pkg::FUNC_VISIT, 8'd0,   8'd0,   3'd7, 32'hFFFFFFFF, 1,
                sgas_pkg::STATUS_NOFREE, 8'd8);
        // Empty cell never moves.
        add_row(sgas_pkg::FUNC_VISIT, 8'd5,   8'd5,   3'd0, 32'd0, 1,
                sgas_pkg::STATUS_STAY, 8'd0);
        add_row(sgas_pkg::FUNC_LOAD,  8'd10,  8'd10,  3'd0, 32'd0, 1,
                sgas_pkg::STATUS_STAY, 8'd0);
        add_row(sgas_pkg::FUNC_VISIT, 8'd0,   8'd0,   3'd0, 32'hFFFFFFFF, 0,
                sgas_pkg::STATUS_STAY, 8'd0);
        add_row(sgas_pkg::FUNC_VISIT, 8'd255, 8'd255, 3'd0, 32'd0, 0,
                sgas_pkg::STATUS_STAY, 8'd0);
        add_row(sgas_pkg::FUNC_LOAD,  8'd255, 8'd255, 3'd7, 32'd0, 1,
                sgas_pkg::STATUS_STAY, 8'd0);
        add_row(sgas_pkg::FUNC_LOAD,  8'd128, 8'd127, 3'd0, 32'd0, 1,
                sgas_pkg::STATUS_STAY, 8'd0);
        // Stale entry: the free list names a now occupied cell.
        add_row(sgas_pkg::FUNC_LOAD,  8'd128, 8'd127, 3'd5, 32'd0, 1,
                sgas_pkg::STATUS_STAY, 8'd0);
        add_row(sgas_pkg::FUNC_VISIT, 8'd10,  8'd10,  3'd0, 32'd1, 0,
                sgas_pkg::STATUS_STAY, 8'd0);
        add_row(sgas_pkg::FUNC_VISIT, 8'd1,   8'd1,   3'd0, 32'd3, 0,
                sgas_pkg::STATUS_STAY, 8'd0);
        add_row(sgas_pkg::FUNC_VISIT, 8'd0,   8'd1,   3'd0, 32'h80000000, 0,
                sgas_pkg::STATUS_STAY, 8'd0);
        foreach (steps[k]) send_word(steps[k].w, steps[k].typed, steps[k].res);
        drain();

        // Random phases, each with its own register setting written while idle.
        for (int p = 0; p < PHASES; p++) begin
            if (p == 0) rad = 3'd0;
            else if (p == 1) rad = 3'd7;
            else rad = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(4, 6))
                                                   : 3'($urandom_range(1, 3));
            for (int b = 0; b < 7; b++) tol_word[8*b +: 8] = 8'($urandom_range(0, 9));
            if (p == 3) tol_word = '1;
            if (p == 4) tol_word = '0;
            write_reg(sgas_pkg::CFG_RADIUS, {53'd0, rad});
            write_reg(sgas_pkg::CFG_UNIFORM, {55'd0, p[0]});
            pick = $urandom_range(0, 3);
            write_reg(sgas_pkg::CFG_TOL_SHARED, (p == 2) ? 56'd255 : (p == 5) ? 56'd0 :
                                      (pick == 0) ? {48'd0, 8'($urandom)}
                                                  : {48'd0, 8'($urandom_range(0, 8))});
            write_reg(sgas_pkg::CFG_TOL_COLOUR, tol_word);
            repeat (2) @(posedge i_clk);

            no_idle = (p % 4 == 2);
            base_r = 8'($urandom);
            base_c = 8'($urandom);
            for (int n = 0; n < PHASE_LEN; n++) begin
                // Hold off once mid-phase until every pending result is back.
                if (p == 6 && n == PHASE_LEN / 2) drain();
                w.random_value = $urandom;
                w.colour       = 3'($urandom_range(0, 7));
                if ($urandom_range(0, 9) == 0) begin
                    w.row = 8'($urandom);
                    w.col = 8'($urandom);
                end else begin
                    w.row = base_r + 8'($urandom_range(0, 11));
                    w.col = base_c + 8'($urandom_range(0, 11));
                end
                w.func = ($urandom_range(0, 99) < 40) ? sgas_pkg::FUNC_LOAD
                                                      : sgas_pkg::FUNC_VISIT;
                if (w.func == sgas_pkg::FUNC_LOAD && $urandom_range(0, 3) == 0) w.colour = 3'd0;
                send_word(w, 1'b0, '0);
            end
            drain();
        end
        no_idle = 1'b0;

        $display("Sent %0d words over %0d register phases with %0d register writes.",
                 n_words, PHASES, n_cfg);
        $display("Agents moved %0d times and were stuck without a free cell %0d times.",
                 n_moves, n_nofree);
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Bound the run: clear pass plus every word at its slowest with long stalls.
    initial begin
        #20ms;
        $display("Timeout with %0d results pending", pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
